>>> src/lkr_pkg.sv
// shared constants, codes and control types for the lru-k frame replacer
package lkr_pkg;

    localparam int DEF_FRAME_COUNT = 64;
    localparam int DEF_K_MAX       = 8;
    localparam int DEF_STAMP_BITS  = 32;

    localparam logic [3:0] K_RESET   = 4'd2;
    localparam logic [3:0] TALLY_TOP = 4'hF;

    typedef enum logic [1:0] {
        CMD_ACCESS    = 2'd0,
        CMD_SET_EVICT = 2'd1,
        CMD_REMOVE    = 2'd2,
        CMD_EVICT     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_PINNED  = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic exec_op;
        logic scan_clear;
        logic scan_issue;
        logic finish;
    } ctl_t;

endpackage

>>> src/lkr_ram.sv
// generic single write port ram with registered read
module lkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/lkr_ctrl.sv
// command sequencer for the lru-k frame replacer
module lkr_ctrl #(
    parameter int FRAME_COUNT = lkr_pkg::DEF_FRAME_COUNT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [1:0]                     command,
    output logic                           busy,
    output lkr_pkg::ctl_t                  ctl,
    output logic [$clog2(FRAME_COUNT)-1:0] scan_idx
);
    import lkr_pkg::*;

    localparam int FW = $clog2(FRAME_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t        state_reg;
    logic [FW-1:0] idx_reg;
    logic          drain_reg;

    assign busy     = (state_reg != S_IDLE);
    assign scan_idx = idx_reg;

    always_comb
    begin
        ctl.latch      = (state_reg == S_IDLE) && start;
        ctl.exec_op    = (state_reg == S_EXEC);
        ctl.scan_clear = ctl.latch && (cmd_t'(command) == CMD_EVICT);
        ctl.scan_issue = (state_reg == S_SCAN);
        ctl.finish     = (state_reg == S_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg   <= '0;
                        drain_reg <= 1'b0;
                        if (cmd_t'(command) == CMD_EVICT)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    if (idx_reg == FW'(FRAME_COUNT - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (drain_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    drain_reg <= 1'b1;
                end
                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/lkr_datapath.sv
// frame state, history memories, victim scan and result registers
module lkr_datapath #(
    parameter int FRAME_COUNT = lkr_pkg::DEF_FRAME_COUNT,
    parameter int K_MAX       = lkr_pkg::DEF_K_MAX,
    parameter int STAMP_BITS  = lkr_pkg::DEF_STAMP_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lkr_pkg::ctl_t                  ctl,
    input  logic [$clog2(FRAME_COUNT)-1:0] scan_idx,
    input  logic [1:0]                     command,
    input  logic [7:0]                     frame_index,
    input  logic                           evictable_value,
    input  logic                           cfg_write_en,
    input  logic [3:0]                     cfg_write_data,
    output logic                           result_valid,
    output logic [1:0]                     status,
    output logic [5:0]                     victim_frame,
    output logic [6:0]                     evictable_count
);
    import lkr_pkg::*;

    localparam int FW = $clog2(FRAME_COUNT);
    localparam int PW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CW = $clog2(FRAME_COUNT + 1);
    localparam int MW = 4 + PW;
    localparam int SB = STAMP_BITS;
    localparam int HIST_DEPTH = FRAME_COUNT * (1 << PW);
    localparam logic [PW-1:0] POS_FIRST = PW'(1 % K_MAX);
    localparam logic [PW-1:0] POS_LAST  = PW'(K_MAX - 1);
    localparam logic [5:0]    KMAX6     = 6'(K_MAX);

    // configuration and command registers
    logic [3:0]  kcfg_reg;
    cmd_t        cmd_reg;
    logic [FW-1:0] frame_reg;
    logic        invalid_reg;
    logic        ev_val_reg;

    // frame state
    logic [SB-1:0]          clock_reg, clock_next, clock_ticked;
    logic [FRAME_COUNT-1:0] tracked_reg, tracked_next;
    logic [FRAME_COUNT-1:0] evict_reg, evict_next;
    logic [CW-1:0]          total_reg, total_next;

    // scan pipeline
    logic          s1_valid_reg;
    logic [FW-1:0] s1_frame_reg;
    logic          s2_valid_reg, s2_short_reg, s2_elig_reg;
    logic [FW-1:0] s2_frame_reg;
    logic [SB-1:0] best_short_reg, best_long_reg;
    logic [FW-1:0] id_short_reg, id_long_reg;
    logic          found_short_reg, found_any_reg;

    // result
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    logic [FW-1:0] victim_reg, victim_next;

    // memories
    logic                          meta_we;
    logic [MW-1:0]                 meta_wdata, meta_rdata;
    logic [FW-1:0]                 meta_raddr;
    logic                          hist_we;
    logic [$clog2(HIST_DEPTH)-1:0] hist_waddr, hist_raddr;
    logic [SB-1:0]                 hist_rdata;

    logic [3:0]    tally;
    logic [PW-1:0] pos;
    logic [4:0]    k_eff;
    logic [5:0]    ring_sum, ring_wrap;
    logic [PW-1:0] hist_idx;
    logic          s1_short;
    logic [FW-1:0] victim_sel;
    logic [31:0]   count_wide, victim_wide;

    assign tally = meta_rdata[MW-1 -: 4];
    assign pos   = meta_rdata[PW-1:0];

    always_comb
    begin
        if (kcfg_reg == 4'd0)
        begin
            k_eff = 5'd1;
        end
        else if (5'(kcfg_reg) > 5'(K_MAX))
        begin
            k_eff = 5'(K_MAX);
        end
        else
        begin
            k_eff = 5'(kcfg_reg);
        end
    end

    assign clock_ticked = (&clock_reg) ? clock_reg : clock_reg + 1'b1;

    // ring slot holding the k-th most recent stamp, or slot 0 (the first stamp) for frames with fewer than k accesses
    assign ring_sum  = 6'(pos) + KMAX6 - 6'(k_eff);
    assign ring_wrap = (ring_sum >= KMAX6) ? ring_sum - KMAX6 : ring_sum;
    assign s1_short  = ({1'b0, tally} < k_eff);
    assign hist_idx  = s1_short ? '0 : ring_wrap[PW-1:0];

    assign meta_raddr = ctl.scan_issue ? scan_idx : frame_reg;
    assign hist_raddr = {s1_frame_reg, hist_idx};
    assign victim_sel = found_short_reg ? id_short_reg : id_long_reg;

    always_comb
    begin
        clock_next   = clock_reg;
        tracked_next = tracked_reg;
        evict_next   = evict_reg;
        total_next   = total_reg;
        meta_we      = 1'b0;
        meta_wdata   = '0;
        hist_we      = 1'b0;
        hist_waddr   = {frame_reg, POS_FIRST};
        done_next    = 1'b0;
        status_next  = status_reg;
        victim_next  = victim_reg;

        if (ctl.exec_op)
        begin
            done_next   = 1'b1;
            status_next = ST_OK;
            victim_next = '0;
            if (invalid_reg)
            begin
                status_next = ST_INVALID;
            end
            else
            begin
                clock_next = clock_ticked;
                unique case (cmd_reg)
                    CMD_ACCESS:
                    begin
                        meta_we = 1'b1;
                        hist_we = 1'b1;
                        if (!tracked_reg[frame_reg])
                        begin
                            tracked_next[frame_reg] = 1'b1;
                            evict_next[frame_reg]   = 1'b0;
                            meta_wdata = {4'd1, POS_FIRST};
                            hist_waddr = {frame_reg, {PW{1'b0}}};
                        end
                        else
                        begin
                            meta_wdata = {(tally == TALLY_TOP) ? tally : tally + 4'd1,
                                          (pos == POS_LAST) ? {PW{1'b0}} : pos + 1'b1};
                            hist_waddr = {frame_reg, pos};
                        end
                    end
                    CMD_SET_EVICT:
                    begin
                        if (tracked_reg[frame_reg] && (evict_reg[frame_reg] != ev_val_reg))
                        begin
                            evict_next[frame_reg] = ev_val_reg;
                            if (ev_val_reg)
                            begin
                                total_next = total_reg + 1'b1;
                            end
                            else if (total_reg != '0)
                            begin
                                total_next = total_reg - 1'b1;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (tracked_reg[frame_reg])
                        begin
                            if (!evict_reg[frame_reg])
                            begin
                                status_next = ST_PINNED;
                            end
                            else
                            begin
                                tracked_next[frame_reg] = 1'b0;
                                evict_next[frame_reg]   = 1'b0;
                                if (total_reg != '0)
                                begin
                                    total_next = total_reg - 1'b1;
                                end
                            end
                        end
                    end
                    CMD_EVICT:
                    begin
                        status_next = ST_OK;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
        end
        else if (ctl.finish)
        begin
            done_next = 1'b1;
            if (found_short_reg || found_any_reg)
            begin
                status_next = ST_OK;
                victim_next = victim_sel;
                clock_next  = clock_ticked;
                tracked_next[victim_sel] = 1'b0;
                evict_next[victim_sel]   = 1'b0;
                if (total_reg != '0)
                begin
                    total_next = total_reg - 1'b1;
                end
            end
            else
            begin
                status_next = ST_EMPTY;
                victim_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kcfg_reg        <= K_RESET;
            clock_reg       <= '0;
            tracked_reg     <= '0;
            evict_reg       <= '0;
            total_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            found_short_reg <= 1'b0;
            found_any_reg   <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= ST_OK;
            victim_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                kcfg_reg <= cfg_write_data;
            end
            clock_reg   <= clock_next;
            tracked_reg <= tracked_next;
            evict_reg   <= evict_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            victim_reg  <= victim_next;

            s1_valid_reg <= ctl.scan_issue;
            s2_valid_reg <= s1_valid_reg;

            if (ctl.scan_clear)
            begin
                found_short_reg <= 1'b0;
                found_any_reg   <= 1'b0;
            end
            else if (s2_valid_reg && s2_elig_reg)
            begin
                if (s2_short_reg)
                begin
                    found_short_reg <= 1'b1;
                end
                else if (!found_short_reg)
                begin
                    found_any_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers of the latched command and of the scan
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg     <= cmd_t'(command);
            frame_reg   <= frame_index[FW-1:0];
            invalid_reg <= ({1'b0, frame_index} >= 9'(FRAME_COUNT));
            ev_val_reg  <= evictable_value;
        end
        s1_frame_reg <= scan_idx;
        s2_frame_reg <= s1_frame_reg;
        s2_short_reg <= s1_short;
        s2_elig_reg  <= tracked_reg[s1_frame_reg] & evict_reg[s1_frame_reg];
        if (s2_valid_reg && s2_elig_reg)
        begin
            if (s2_short_reg)
            begin
                if (!found_short_reg || (hist_rdata < best_short_reg))
                begin
                    best_short_reg <= hist_rdata;
                    id_short_reg   <= s2_frame_reg;
                end
            end
            else if (!found_short_reg)
            begin
                if (!found_any_reg || (hist_rdata < best_long_reg))
                begin
                    best_long_reg <= hist_rdata;
                    id_long_reg   <= s2_frame_reg;
                end
            end
        end
    end

    lkr_ram #(
        .WIDTH (MW),
        .DEPTH (FRAME_COUNT)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (frame_reg),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    lkr_ram #(
        .WIDTH (SB),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (clock_ticked),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign count_wide  = 32'(total_reg);
    assign victim_wide = 32'(victim_reg);

    assign result_valid    = done_reg;
    assign status          = status_reg;
    assign victim_frame    = victim_wide[5:0];
    assign evictable_count = count_wide[6:0];

    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) == $countones(evict_reg))
        else $error("evictable total out of step with marks");

    a_evict_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (evict_reg & ~tracked_reg) == '0)
        else $error("evictable mark on untracked frame");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_empty_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_EMPTY)) |-> (victim_reg == '0))
        else $error("victim reported with nothing to evict");

endmodule

>>> src/lru_k_frame_replacer_unit.sv
// top level of the lru-k buffer frame replacer
// one transaction is a command: record an access, set an evictable mark, remove a frame or
// evict a victim. a transaction is taken when start is high and busy is low, and its single
// result appears on status, victim_frame and evictable_count for exactly one cycle while
// result_valid is high; the receiver cannot stall, so it must sample on that cycle. access,
// set-mark and remove run a metadata read, the update, then the result cycle. in evict the
// scan reads one frame's stamp history per cycle from the single read port of the history
// memory, then come the pipeline drain, the removal and the result cycle. the k register is
// written directly through cfg_write_en and cfg_write_data; the user must write it only while
// idle, as the block itself does not enforce this. no clearing pass is needed after reset, as
// history is read only for frames tracked since.
module lru_k_frame_replacer_unit #(
    parameter int FRAME_COUNT = lkr_pkg::DEF_FRAME_COUNT,
    parameter int K_MAX       = lkr_pkg::DEF_K_MAX,
    parameter int STAMP_BITS  = lkr_pkg::DEF_STAMP_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] frame_index,
    input  logic       evictable_value,
    input  logic       cfg_write_en,
    input  logic [3:0] cfg_write_data,
    output logic       result_valid,
    output logic [1:0] status,
    output logic [5:0] victim_frame,
    output logic [6:0] evictable_count
);
    import lkr_pkg::*;

    // sequencer to datapath commands
    ctl_t                           ctl;
    logic [$clog2(FRAME_COUNT)-1:0] scan_idx;

    lkr_ctrl #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .busy     (busy),
        .ctl      (ctl),
        .scan_idx (scan_idx)
    );

    // frame state, memories and victim scan
    lkr_datapath #(
        .FRAME_COUNT (FRAME_COUNT),
        .K_MAX       (K_MAX),
        .STAMP_BITS  (STAMP_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .scan_idx        (scan_idx),
        .command         (command),
        .frame_index     (frame_index),
        .evictable_value (evictable_value),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .result_valid    (result_valid),
        .status          (status),
        .victim_frame    (victim_frame),
        .evictable_count (evictable_count)
    );

endmodule
